/* sv/autoscale_plot_point_mapper_assert.svh */
// Assertion macros for the plot point mapper.
`ifndef AUTOSCALE_PLOT_POINT_MAPPER_ASSERT_SVH
`define AUTOSCALE_PLOT_POINT_MAPPER_ASSERT_SVH

// Overlapping implication, checked outside reset.
`define APM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apm check failed");

// Implication checked in the following cycle.
`define APM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apm check failed");

`endif

/* sv/apm_pkg.sv */
// Shared types and constants of the plot point mapper.
package apm_pkg;

    localparam int COORD_W = 16;
    localparam int CFG_W   = 12;
    localparam int NUM_W   = 28;
    localparam int QUO_W   = 12;
    localparam int PIX_W   = 13;

    localparam logic [1:0] REG_PLOT_WIDTH  = 2'd0;
    localparam logic [1:0] REG_PLOT_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ORIGIN_X    = 2'd2;
    localparam logic [1:0] REG_ORIGIN_Y    = 2'd3;

    localparam logic [CFG_W-1:0] RST_PLOT_WIDTH  = 12'd500;
    localparam logic [CFG_W-1:0] RST_PLOT_HEIGHT = 12'd400;
    localparam logic [CFG_W-1:0] RST_ORIGIN_X    = 12'd100;
    localparam logic [CFG_W-1:0] RST_ORIGIN_Y    = 12'd450;

    // Data ranges of one closed set, handed from front to back.
    typedef struct packed {
        logic signed [COORD_W-1:0] xmin;
        logic signed [COORD_W-1:0] xmax;
        logic signed [COORD_W-1:0] ymin;
        logic signed [COORD_W-1:0] ymax;
    } job_t;

    typedef struct packed {
        logic plot_width_nz;
        logic ranking;
    } back_status_t;

endpackage

/* sv/autoscale_plot_point_mapper.sv */
// Top level of the autoscaling plot point mapper.
// Points load one per cycle (start high, busy low). The point marked last_point
// closes the set; points past MAX_POINTS are dropped. The set is then rank
// sorted by x (stable): the set is handed over, all pairs are compared through
// two read ports of the point store and the last sorted write is made; with an
// idle back end, busy stays high from the closing transaction until that write.
// Each point then passes through a store read, a multiply and a 12-step divider
// per axis, both running in parallel, and appears on the result ports for
// exactly one cycle with result_valid; results cannot be held off. The next set
// may load while the previous one is being emitted; it is sorted once emission ends.
module autoscale_plot_point_mapper #(
    parameter int MAX_POINTS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [apm_pkg::COORD_W-1:0]  x_value,
    input  logic signed [apm_pkg::COORD_W-1:0]  y_value,
    input  logic                                last_point,
    input  logic                                wr_en,
    input  logic [1:0]                          wr_index,
    input  logic [apm_pkg::CFG_W-1:0]           wr_data,
    output logic                                result_valid,
    output logic [apm_pkg::PIX_W-1:0]           pixel_x,
    output logic signed [apm_pkg::PIX_W-1:0]    pixel_y,
    output logic                                range_flat,
    output logic                                last_result
);

`include "autoscale_plot_point_mapper_assert.svh"

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = 2 * apm_pkg::COORD_W;

    logic [apm_pkg::CFG_W-1:0] plot_width_reg;
    logic [apm_pkg::CFG_W-1:0] plot_height_reg;
    logic [apm_pkg::CFG_W-1:0] origin_x_reg;
    logic [apm_pkg::CFG_W-1:0] origin_y_reg;

    logic                  st_we;
    logic [AW-1:0]         st_waddr;
    logic [DW-1:0]         st_wdata;
    logic [AW-1:0]         raddr_a;
    logic [AW-1:0]         raddr_b;
    logic [DW-1:0]         rdata_a;
    logic [DW-1:0]         rdata_b;
    logic                  job_valid;
    apm_pkg::job_t         job;
    logic [CW-1:0]         job_count;
    logic                  pop;
    apm_pkg::back_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plot_width_reg  <= apm_pkg::RST_PLOT_WIDTH;
            plot_height_reg <= apm_pkg::RST_PLOT_HEIGHT;
            origin_x_reg    <= apm_pkg::RST_ORIGIN_X;
            origin_y_reg    <= apm_pkg::RST_ORIGIN_Y;
        end
        else if (wr_en)
        begin
            case (wr_index)
                apm_pkg::REG_PLOT_WIDTH:  plot_width_reg  <= wr_data;
                apm_pkg::REG_PLOT_HEIGHT: plot_height_reg <= wr_data;
                apm_pkg::REG_ORIGIN_X:    origin_x_reg    <= wr_data;
                apm_pkg::REG_ORIGIN_Y:    origin_y_reg    <= wr_data;
                default:                  plot_width_reg  <= plot_width_reg;
            endcase
        end
    end

    apm_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .x_value      (x_value),
        .y_value      (y_value),
        .last_point   (last_point),
        .back_ranking (status.ranking),
        .pop          (pop),
        .busy         (busy),
        .st_we        (st_we),
        .st_waddr     (st_waddr),
        .st_wdata     (st_wdata),
        .job_valid    (job_valid),
        .job          (job),
        .job_count    (job_count)
    );

    // Two copies of the point store give two read ports.
    apm_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_POINTS)
    ) u_store_a (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    apm_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_POINTS)
    ) u_store_b (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    apm_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job),
        .job_count    (job_count),
        .pop          (pop),
        .status       (status),
        .raddr_a      (raddr_a),
        .raddr_b      (raddr_b),
        .rdata_a      (rdata_a),
        .rdata_b      (rdata_b),
        .plot_width   (plot_width_reg),
        .plot_height  (plot_height_reg),
        .origin_x     (origin_x_reg),
        .origin_y     (origin_y_reg),
        .result_valid (result_valid),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .range_flat   (range_flat),
        .last_result  (last_result)
    );

    // The store is never written while the back end is sorting out of it.
    `APM_ASSERT_NOW(a_no_write_in_sort, clk, rst_n, st_we, !status.ranking)
    // A closing transaction locks the input until the set is sorted.
    `APM_ASSERT_NEXT(a_close_busy, clk, rst_n, start && !busy && last_point, busy)
    // Results of one set are spaced by the per-point pipeline.
    `APM_ASSERT_NEXT(a_result_gap, clk, rst_n, result_valid, !result_valid)
    // Zero plot width puts every result on the origin column.
    `APM_ASSERT_NOW(a_zero_width, clk, rst_n,
        result_valid && !status.plot_width_nz && !$past(wr_en),
        pixel_x == {1'b0, origin_x_reg})

endmodule

/* sv/apm_ram.sv */
// Generic single write, single read RAM with registered read data.
module apm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/apm_div.sv */
// Restoring divider, one quotient bit per cycle; quotient known to fit QUO_W bits.
module apm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [apm_pkg::NUM_W-1:0]     num,
    input  logic [apm_pkg::COORD_W-1:0]   den,
    output logic                          done,
    output logic [apm_pkg::QUO_W-1:0]     quo
);

    localparam int QW = apm_pkg::QUO_W;
    localparam int DW = apm_pkg::COORD_W;
    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] rem_reg;
    logic [QW-1:0] sh_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    assign trial = {rem_reg, sh_reg[QW-1]};
    assign ge    = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(QW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[apm_pkg::NUM_W-1:QW];
            sh_reg  <= num[QW-1:0];
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            sh_reg  <= {sh_reg[QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg;

endmodule

/* sv/apm_front.sv */
// Front end: takes points, fills the point store, tracks ranges, posts a job slot.
module apm_front #(
    parameter int MAX_POINTS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [apm_pkg::COORD_W-1:0]  x_value,
    input  logic signed [apm_pkg::COORD_W-1:0]  y_value,
    input  logic                                last_point,
    input  logic                                back_ranking,
    input  logic                                pop,
    output logic                                busy,
    output logic                                st_we,
    output logic [$clog2(MAX_POINTS)-1:0]       st_waddr,
    output logic [2*apm_pkg::COORD_W-1:0]       st_wdata,
    output logic                                job_valid,
    output apm_pkg::job_t                       job,
    output logic [$clog2(MAX_POINTS+1)-1:0]     job_count
);

    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0]      count_reg;
    apm_pkg::job_t      rng_reg;
    apm_pkg::job_t      rng_next;
    logic               slot_valid_reg;
    apm_pkg::job_t      slot_reg;
    logic [CW-1:0]      slot_count_reg;
    logic               accept;
    logic               store;
    logic               first;

    assign busy   = slot_valid_reg || back_ranking;
    assign accept = start && !busy;
    assign store  = accept && (count_reg < CW'(MAX_POINTS));
    assign first  = count_reg == '0;

    always_comb
    begin
        rng_next = rng_reg;
        if (store)
        begin
            if (first || x_value < rng_reg.xmin) rng_next.xmin = x_value;
            if (first || x_value > rng_reg.xmax) rng_next.xmax = x_value;
            if (first || y_value < rng_reg.ymin) rng_next.ymin = y_value;
            if (first || y_value > rng_reg.ymax) rng_next.ymax = y_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            slot_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                slot_valid_reg <= 1'b0;
            end
            if (accept && last_point)
            begin
                count_reg      <= '0;
                slot_valid_reg <= 1'b1;
            end
            else if (store)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rng_reg <= rng_next;
        if (accept && last_point)
        begin
            slot_reg       <= rng_next;
            slot_count_reg <= store ? count_reg + 1'b1 : count_reg;
        end
    end

    assign st_we     = store;
    assign st_waddr  = count_reg[$clog2(MAX_POINTS)-1:0];
    assign st_wdata  = {x_value, y_value};
    assign job_valid = slot_valid_reg;
    assign job       = slot_reg;
    assign job_count = slot_count_reg;

endmodule

/* sv/apm_back.sv */
// Back end: rank sort into a second store, then scale and emit each point.
module apm_back #(
    parameter int MAX_POINTS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                job_valid,
    input  apm_pkg::job_t                       job,
    input  logic [$clog2(MAX_POINTS+1)-1:0]     job_count,
    output logic                                pop,
    output apm_pkg::back_status_t               status,
    output logic [$clog2(MAX_POINTS)-1:0]       raddr_a,
    output logic [$clog2(MAX_POINTS)-1:0]       raddr_b,
    input  logic [2*apm_pkg::COORD_W-1:0]       rdata_a,
    input  logic [2*apm_pkg::COORD_W-1:0]       rdata_b,
    input  logic [apm_pkg::CFG_W-1:0]           plot_width,
    input  logic [apm_pkg::CFG_W-1:0]           plot_height,
    input  logic [apm_pkg::CFG_W-1:0]           origin_x,
    input  logic [apm_pkg::CFG_W-1:0]           origin_y,
    output logic                                result_valid,
    output logic [apm_pkg::PIX_W-1:0]           pixel_x,
    output logic signed [apm_pkg::PIX_W-1:0]    pixel_y,
    output logic                                range_flat,
    output logic                                last_result
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int XW = apm_pkg::COORD_W;
    localparam int NW = apm_pkg::NUM_W;
    localparam int PW = apm_pkg::PIX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANK,
        S_DRAIN,
        S_READ,
        S_MUL,
        S_DIV
    } state_t;

    state_t         state_reg;
    logic [CW-1:0]  n_reg;
    apm_pkg::job_t  rng_reg;
    logic [AW-1:0]  i_reg;
    logic [AW-1:0]  j_reg;
    logic [AW-1:0]  k_reg;
    logic           d_v_reg;
    logic [AW-1:0]  di_reg;
    logic [AW-1:0]  dj_reg;
    logic           dlast_reg;
    logic [AW-1:0]  rank_reg;
    logic           result_valid_reg;
    logic [PW-1:0]  pixel_x_reg;
    logic [PW-1:0]  pixel_y_reg;
    logic           range_flat_reg;
    logic           last_result_reg;

    logic [AW-1:0]  nm1;
    logic signed [XW-1:0] xa;
    logic signed [XW-1:0] xb;
    logic           less;
    logic [AW-1:0]  rank_sum;
    logic           srt_we;
    logic [2*XW-1:0] srt_rdata;
    logic [XW:0]    xr;
    logic [XW:0]    yr;
    logic           xflat;
    logic           yflat;
    logic [XW:0]    dx;
    logic [XW:0]    dy;
    logic [NW-1:0]  num_x;
    logic [NW-1:0]  num_y;
    logic           div_start;
    logic           done_x;
    logic           done_y;
    logic [apm_pkg::QUO_W-1:0] quo_x;
    logic [apm_pkg::QUO_W-1:0] quo_y;
    logic [apm_pkg::QUO_W-1:0] offx;
    logic [apm_pkg::QUO_W-1:0] offy;

    assign nm1 = AW'(n_reg - 1'b1);

    // Rank of element di: smaller x anywhere, or equal x at a lower index.
    assign xa       = rdata_a[2*XW-1:XW];
    assign xb       = rdata_b[2*XW-1:XW];
    assign less     = (xb < xa) || ((xb == xa) && (dj_reg < di_reg));
    assign rank_sum = rank_reg + AW'(less);
    assign srt_we   = d_v_reg && dlast_reg;

    assign raddr_a = i_reg;
    assign raddr_b = j_reg;

    apm_ram #(
        .WIDTH (2 * XW),
        .DEPTH (MAX_POINTS)
    ) u_sorted (
        .clk   (clk),
        .we    (srt_we),
        .waddr (rank_sum),
        .wdata (rdata_a),
        .raddr (k_reg),
        .rdata (srt_rdata)
    );

    assign xr    = {rng_reg.xmax[XW-1], rng_reg.xmax} - {rng_reg.xmin[XW-1], rng_reg.xmin};
    assign yr    = {rng_reg.ymax[XW-1], rng_reg.ymax} - {rng_reg.ymin[XW-1], rng_reg.ymin};
    assign xflat = xr == '0;
    assign yflat = yr == '0;
    assign dx    = {srt_rdata[2*XW-1], srt_rdata[2*XW-1:XW]} -
                   {rng_reg.xmin[XW-1], rng_reg.xmin};
    assign dy    = {srt_rdata[XW-1], srt_rdata[XW-1:0]} -
                   {rng_reg.ymin[XW-1], rng_reg.ymin};
    assign num_x = NW'(dx[XW-1:0] * plot_width);
    assign num_y = NW'(dy[XW-1:0] * plot_height) + NW'(yr[XW-1:0] - 1'b1);
    assign div_start = state_reg == S_MUL;

    apm_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_x),
        .den   (xr[XW-1:0]),
        .done  (done_x),
        .quo   (quo_x)
    );

    apm_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_y),
        .den   (yr[XW-1:0]),
        .done  (done_y),
        .quo   (quo_y)
    );

    assign offx = xflat ? '0 : quo_x;
    assign offy = yflat ? '0 : quo_y;

    assign pop = (state_reg == S_IDLE) && job_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            d_v_reg          <= 1'b0;
            rank_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (d_v_reg)
            begin
                rank_reg <= dlast_reg ? '0 : rank_sum;
            end
            case (state_reg)
                S_IDLE:
                begin
                    d_v_reg <= 1'b0;
                    if (job_valid)
                    begin
                        state_reg <= S_RANK;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        rank_reg  <= '0;
                    end
                end
                S_RANK:
                begin
                    d_v_reg <= 1'b1;
                    if (j_reg == nm1)
                    begin
                        j_reg <= '0;
                        if (i_reg == nm1)
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    d_v_reg   <= 1'b0;
                    k_reg     <= '0;
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (done_x && done_y)
                    begin
                        result_valid_reg <= 1'b1;
                        if (k_reg == nm1)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            n_reg   <= job_count;
            rng_reg <= job;
        end
        di_reg    <= i_reg;
        dj_reg    <= j_reg;
        dlast_reg <= j_reg == nm1;
        if (state_reg == S_DIV && done_x && done_y)
        begin
            pixel_x_reg     <= {1'b0, origin_x} + {1'b0, offx};
            pixel_y_reg     <= {1'b0, origin_y} - {1'b0, offy};
            range_flat_reg  <= xflat || yflat;
            last_result_reg <= k_reg == nm1;
        end
    end

    assign status.ranking       = (state_reg == S_RANK) || (state_reg == S_DRAIN);
    assign status.plot_width_nz = plot_width != '0;

    assign result_valid = result_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign range_flat   = range_flat_reg;
    assign last_result  = last_result_reg;

endmodule

/* bench/tb_autoscale_plot_point_mapper.sv */
// Self-checking testbench for the autoscaling plot point mapper.
module tb_autoscale_plot_point_mapper;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXP       = 32;
    localparam int DRAIN_WAIT = 40;
    localparam int STALL_LIM  = 20000;
    localparam int COORD_W    = apm_pkg::COORD_W;
    localparam int CFG_W      = apm_pkg::CFG_W;
    localparam int PIX_W      = apm_pkg::PIX_W;

    typedef struct {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic             flat;
        logic             last;
    } pixel_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic signed [COORD_W-1:0] x_value = '0;
    logic signed [COORD_W-1:0] y_value = '0;
    logic                      last_point = 1'b0;
    logic                      wr_en = 1'b0;
    logic [1:0]                wr_index = '0;
    logic [CFG_W-1:0]          wr_data = '0;
    logic                      result_valid;
    logic [PIX_W-1:0]          pixel_x;
    logic signed [PIX_W-1:0]   pixel_y;
    logic                      range_flat;
    logic                      last_result;

    autoscale_plot_point_mapper #(.MAX_POINTS(MAXP)) DUT (.*);

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    logic [CFG_W-1:0] plot_w, plot_h, org_x, org_y;
    int               xs [MAXP];
    int               ys [MAXP];
    int               npts;
    pixel_t           pending_pixels [$];

    int  errors = 0;
    int  n_items = 0;
    int  n_sets = 0;
    int  n_results = 0;
    int  stall = 0;
    bit  no_idle = 0;

    // Stable sort by x, find ranges, queue one pixel per stored point.
    task automatic map_set();
        int     kx, ky, j;
        int     xmin, xmax, ymin, ymax;
        longint xr, yr, offx, offy;
        pixel_t p;
        for (int i = 1; i < npts; i++) begin
            kx = xs[i];
            ky = ys[i];
            j = i;
            while (j > 0 && xs[j-1] > kx) begin
                xs[j] = xs[j-1];
                ys[j] = ys[j-1];
                j--;
            end
            xs[j] = kx;
            ys[j] = ky;
        end
        xmin = xs[0];
        xmax = xs[npts-1];
        ymin = ys[0];
        ymax = ys[0];
        for (int i = 1; i < npts; i++) begin
            if (ys[i] < ymin) ymin = ys[i];
            if (ys[i] > ymax) ymax = ys[i];
        end
        xr = xmax - xmin;
        yr = ymax - ymin;
        for (int i = 0; i < npts; i++) begin
            offx = (xr != 0) ? (longint'(xs[i] - xmin) * plot_w) / xr : 0;
            offy = (yr != 0) ? (longint'(ys[i] - ymin) * plot_h + yr - 1) / yr : 0;
            p.px   = PIX_W'(longint'(org_x) + offx);
            p.py   = PIX_W'(longint'(org_y) - offy);
            p.flat = (xr == 0 || yr == 0);
            p.last = (i == npts - 1);
            pending_pixels.push_back(p);
        end
        npts = 0;
        n_sets++;
    endtask

    task automatic accept_point(int x, int y, bit last);
        if (npts < MAXP) begin
            xs[npts] = x;
            ys[npts] = y;
            npts++;
        end
        if (last && npts != 0) map_set();
    endtask

    task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              bit last);
        int gap;
        gap = (!no_idle && $urandom_range(0, 99) < 30) ? $urandom_range(1, 2) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        x_value    <= x;
        y_value    <= y;
        last_point <= last;
        do @(posedge clk); while (busy);
        accept_point(int'(x), int'(y), last);
        n_items++;
    endtask

    // Stop sending and let every expected pixel come out.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_plot(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                            logic [CFG_W-1:0] ox, logic [CFG_W-1:0] oy);
        logic [CFG_W-1:0] vals [4];
        logic [1:0]       idx [4];
        vals = '{w, h, ox, oy};
        idx  = '{apm_pkg::REG_PLOT_WIDTH, apm_pkg::REG_PLOT_HEIGHT,
                 apm_pkg::REG_ORIGIN_X, apm_pkg::REG_ORIGIN_Y};
        for (int i = 0; i < 4; i++) begin
            wr_en    <= 1'b1;
            wr_index <= idx[i];
            wr_data  <= vals[i];
            @(posedge clk);
        end
        wr_en <= 1'b0;
        plot_w = w;
        plot_h = h;
        org_x  = ox;
        org_y  = oy;
        @(posedge clk);
    endtask

    task automatic send_random_set(int n, bit narrow);
        int x, y;
        for (int i = 0; i < n; i++) begin
            x = narrow ? $urandom_range(0, 6) - 3 : $urandom_range(0, 65535) - 32768;
            y = narrow ? $urandom_range(0, 6) - 3 : $urandom_range(0, 65535) - 32768;
            send_point(x[COORD_W-1:0], y[COORD_W-1:0], i == n - 1);
        end
    endtask

    task automatic test_reset_defaults();
        send_point(16'sh8000, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, 16'sh8000, 1'b0);
        send_point(16'sh0000, 16'sh0001, 1'b1);
        // single point lands on the origin
        send_point(16'sh1234, -16'sd77, 1'b1);
        // flat x axis
        send_point(16'sd5, 16'sd1, 1'b0);
        send_point(16'sd5, 16'sd9, 1'b1);
        // flat y, duplicate x keeps arrival order
        send_point(16'sd3, 16'sd4, 1'b0);
        send_point(-16'sd2, 16'sd4, 1'b0);
        send_point(16'sd3, 16'sd4, 1'b1);
        drain();
    endtask

    task automatic test_config_extremes();
        set_plot(12'd4095, 12'd4095, 12'd4095, 12'd0);
        send_point(16'sh8000, 16'sh8000, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_point(16'sd1, -16'sd1, 1'b1);
        drain();
        set_plot(12'd1, 12'd1, 12'd0, 12'd4095);
        send_point(-16'sd10, 16'sd3, 1'b0);
        send_point(16'sd10, 16'sd7, 1'b0);
        send_point(16'sd0, 16'sd4, 1'b1);
        drain();
        // zero extent on both axes
        set_plot(12'd0, 12'd0, 12'd77, 12'd88);
        send_point(16'sd1, 16'sd2, 1'b0);
        send_point(16'sd9, 16'sd8, 1'b1);
        drain();
    endtask

    task automatic test_store_overflow();
        set_plot(12'd640, 12'd480, 12'd10, 12'd470);
        // two extra points are dropped; the mark on the dropped one still closes
        send_random_set(MAXP + 2, 1'b0);
        drain();
    endtask

    task automatic test_random_sets();
        int sent;
        sent = 0;
        while (sent < 120) begin
            int n;
            no_idle = (sent >= 60 && sent < 100);
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, MAXP) : $urandom_range(1, 6);
            send_random_set(n, $urandom_range(0, 2) == 0);
            sent += n;
            if ($urandom_range(0, 7) == 0) begin
                drain();
                set_plot(CFG_W'($urandom_range(1, 4095)), CFG_W'($urandom_range(1, 4095)),
                         CFG_W'($urandom_range(0, 4095)), CFG_W'($urandom_range(0, 4095)));
            end
        end
        no_idle = 0;
    endtask

    always @(posedge clk) begin
        pixel_t e;
        if (rst_n) begin
            if ((start && !busy) || result_valid) stall <= 0;
            else stall <= stall + 1;
            if (stall >= STALL_LIM) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIM);
                $display("Verification failed");
                $finish;
            end
            if (result_valid) begin
                n_results++;
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected result px=%0d py=%0d", $time, pixel_x, pixel_y);
                    errors++;
                end
                else begin
                    e = pending_pixels.pop_front();
                    if (pixel_x !== e.px || pixel_y !== e.py || range_flat !== e.flat ||
                        last_result !== e.last) begin
                        $display("%0t: expected px=%0d py=%0d flat=%b last=%b,",
                                 $time, e.px, $signed(e.py), e.flat, e.last);
                        $display("    got px=%0d py=%0d flat=%b last=%b",
                                 pixel_x, pixel_y, range_flat, last_result);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        plot_w = apm_pkg::RST_PLOT_WIDTH;
        plot_h = apm_pkg::RST_PLOT_HEIGHT;
        org_x  = apm_pkg::RST_ORIGIN_X;
        org_y  = apm_pkg::RST_ORIGIN_Y;
        npts   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_config_extremes();
        test_store_overflow();
        test_random_sets();
        drain();
        if (pending_pixels.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_pixels.size());
            errors++;
        end
        $display("Ran %0d points in %0d sets, %0d pixels checked, %0d errors",
                 n_items, n_sets, n_results, errors);
        $display("Covered extremes, flat ranges, zero extent, store overflow, random configs");
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
